FILE: design/zmpn_pkg.sv
// Shared types and constants for the zero-mean peak normalizer.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package zmpn_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int OUT_BITS    = 16;

    localparam int ADDR_W    = $clog2(MAX_SAMPLES);
    localparam int CNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W     = SAMPLE_BITS + ADDR_W;
    localparam int PEAK_W    = SUM_W + 1;
    localparam int DEV_W     = PEAK_W + 1;
    localparam int REM_W     = PEAK_W + 1;
    localparam int FRAC_BITS = OUT_BITS - 1;
    localparam int QUOT_W    = FRAC_BITS + 1;
    localparam int STEP_W    = $clog2(QUOT_W + 1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_sample;
    } t_in;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] norm_value;
        logic                       available;
        logic                       end_of_window;
    } t_out;

    typedef struct packed {
        logic                          we;
        logic [ADDR_W-1:0]             waddr;
        logic signed [SAMPLE_BITS-1:0] wdata;
        logic [ADDR_W-1:0]             raddr;
    } t_store_req;

    typedef struct packed {
        logic              start;
        logic [PEAK_W-1:0] num;
        logic [PEAK_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_DEV,
        ST_SCAN_MAX,
        ST_CHECK,
        ST_NORM_RD,
        ST_NORM_DEV,
        ST_NORM_GO,
        ST_NORM_DIV
    } t_state;

endpackage

FILE: design/zmpn_store.sv
// Sample window memory: one write port, one registered read port.
// Depends on zmpn_pkg.
`timescale 1ns / 1ps

module zmpn_store (
    input  logic                                   i_clk,
    input  zmpn_pkg::t_store_req                   i_req,
    output logic signed [zmpn_pkg::SAMPLE_BITS-1:0] o_rdata
);
    import zmpn_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_mem [MAX_SAMPLES];
    logic signed [SAMPLE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/zmpn_div.sv
// Restoring divider, one quotient bit per cycle: floor(num * 2^FRAC_BITS / den).
// Expects num <= den. Depends on zmpn_pkg.
`timescale 1ns / 1ps

module zmpn_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  zmpn_pkg::t_div_req i_req,
    output zmpn_pkg::t_div_rsp o_rsp
);
    import zmpn_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [REM_W-1:0]  r_rem;
    logic [PEAK_W-1:0] r_den;
    logic [QUOT_W-1:0] r_quot;

    logic              ge;
    logic [REM_W-1:0]  diff;
    logic [REM_W-1:0]  n_rem;

    always_comb begin
        ge    = r_rem >= REM_W'(r_den);
        diff  = ge ? (r_rem - REM_W'(r_den)) : r_rem;
        // diff < den, so the top bit is free for the shift
        n_rem = {diff[REM_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(QUOT_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= REM_W'(i_req.num);
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[QUOT_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

FILE: design/zero_mean_peak_normalizer.sv
// Top level: sample loading, scan/normalize sequencer and output register.
// Depends on zmpn_pkg, zmpn_store and zmpn_div.
//
//  channel | ports                      | handshake
//  --------+----------------------------+--------------------------------------
//  input   | i_req (sample, last_sample)| taken when start && !busy
//  result  | o_result                   | o_valid strobe, one cycle, no stall
//
// A sample without the last flag is stored and summed. The last flag closes
// the window: a scan reads each stored sample to find the peak deviation,
// a check follows, then, unless the window is degenerate, each sample is
// normalized (memory read, deviation, 16-step divider).
// Reset (synchronous, active low) clears count, sum and peak; the memory is
// not cleared. The receiver cannot stall; busy is high while a window closes.
`timescale 1ns / 1ps

module zero_mean_peak_normalizer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  zmpn_pkg::t_in    i_req,
    output logic             o_valid,
    output zmpn_pkg::t_out   o_result
);
    import zmpn_pkg::*;

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic [PEAK_W-1:0]         r_peak, n_peak;
    logic [ADDR_W-1:0]         r_idx, n_idx;
    logic signed [DEV_W-1:0]   r_dev, n_dev;
    logic                      r_out_valid, n_out_valid;
    t_out                      r_out, n_out;

    t_store_req                store_req;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;
    logic signed [SAMPLE_BITS-1:0] rdata;

    logic signed [DEV_W-1:0]   dev_calc;
    logic [PEAK_W-1:0]         dev_mag;
    logic                      idx_last;
    logic                      degenerate;
    logic signed [OUT_BITS-1:0] q_signed;

    zmpn_store u_store (
        .i_clk   (i_clk),
        .i_req   (store_req),
        .o_rdata (rdata)
    );

    zmpn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // d = x*count - sum, exact in DEV_W bits
    always_comb begin
        dev_calc = DEV_W'(rdata) * DEV_W'($signed({1'b0, r_count})) - DEV_W'(r_sum);
        dev_mag  = r_dev[DEV_W-1] ? PEAK_W'(-r_dev) : PEAK_W'(r_dev);
        idx_last = CNT_W'(r_idx) == (r_count - CNT_W'(1));
        degenerate = (r_count < CNT_W'(2)) || (r_peak == '0);
        if (r_dev[DEV_W-1]) begin
            q_signed = $signed(OUT_BITS'(~div_rsp.quot + QUOT_W'(1)));
        end else if (div_rsp.quot[QUOT_W-1]) begin
            q_signed = $signed({1'b0, {FRAC_BITS{1'b1}}});  // +1.0 saturates
        end else begin
            q_signed = $signed(OUT_BITS'(div_rsp.quot));
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start && i_req.last_sample) begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:  n_state = ST_SCAN_DEV;
            ST_SCAN_DEV: n_state = ST_SCAN_MAX;
            ST_SCAN_MAX: n_state = idx_last ? ST_CHECK : ST_SCAN_RD;
            ST_CHECK:    n_state = degenerate ? ST_IDLE : ST_NORM_RD;
            ST_NORM_RD:  n_state = ST_NORM_DEV;
            ST_NORM_DEV: n_state = ST_NORM_GO;
            ST_NORM_GO:  n_state = ST_NORM_DIV;
            ST_NORM_DIV: begin
                if (div_rsp.done) begin
                    n_state = idx_last ? ST_IDLE : ST_NORM_RD;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count     = r_count;
        n_sum       = r_sum;
        n_peak      = r_peak;
        n_idx       = r_idx;
        n_dev       = r_dev;
        n_out       = r_out;
        n_out_valid = 1'b0;

        store_req.we    = 1'b0;
        store_req.waddr = r_count[ADDR_W-1:0];
        store_req.wdata = i_req.sample;
        store_req.raddr = r_idx;

        div_req.start = 1'b0;
        div_req.num   = dev_mag;
        div_req.den   = r_peak;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    // samples past capacity are dropped
                    if (r_count < CNT_W'(MAX_SAMPLES)) begin
                        store_req.we = 1'b1;
                        n_count      = r_count + CNT_W'(1);
                        n_sum        = r_sum + SUM_W'(i_req.sample);
                    end
                    if (i_req.last_sample) begin
                        n_idx  = '0;
                        n_peak = '0;
                    end
                end
            end
            ST_SCAN_DEV, ST_NORM_DEV: begin
                n_dev = dev_calc;
            end
            ST_SCAN_MAX: begin
                if (dev_mag > r_peak) begin
                    n_peak = dev_mag;
                end
                n_idx = r_idx + ADDR_W'(1);
            end
            ST_CHECK: begin
                n_idx = '0;
                if (degenerate) begin
                    n_out.norm_value    = '0;
                    n_out.available     = 1'b0;
                    n_out.end_of_window = 1'b1;
                    n_out_valid         = 1'b1;
                    n_count             = '0;
                    n_sum               = '0;
                end
            end
            ST_NORM_GO: begin
                div_req.start = 1'b1;
            end
            ST_NORM_DIV: begin
                if (div_rsp.done) begin
                    n_out.norm_value    = q_signed;
                    n_out.available     = 1'b1;
                    n_out.end_of_window = idx_last;
                    n_out_valid         = 1'b1;
                    n_idx               = r_idx + ADDR_W'(1);
                    if (idx_last) begin
                        n_count = '0;
                        n_sum   = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_peak      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_peak      <= n_peak;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dev <= n_dev;
        r_out <= n_out;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef SYNTH
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    a_degen_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.available) |-> o_result.end_of_window)
        else $error("degenerate result not marked end of window");

    a_close_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> (o_valid && o_result.end_of_window))
        else $error("window closed without a final result");

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_NORM_DIV))
        else $error("divider finished outside the divide state");
`endif

endmodule
